@@ sv/imq_pkg.sv @@
// Shared types and codes for the indexed min-queue tournament tree.
// Holds the item payload structs and the operation codes.
// No dependencies; compile first.
package imq_pkg;

  localparam int ID_W  = 11;
  localparam int KEY_W = 32;

  localparam logic [1:0] MODE_UPDATE  = 2'd0;
  localparam logic [1:0] MODE_POP_MIN = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ID_W-1:0]  entry_id;
    logic [KEY_W-1:0] new_key;
  } imq_in_t;

  typedef struct packed {
    logic             key_changed;
    logic             bad_request;
    logic             queue_empty;
    logic [ID_W-1:0]  min_entry;
    logic             entry_present;
    logic [KEY_W-1:0] entry_key;
  } imq_out_t;

endpackage

@@ sv/imq_stream_if.sv @@
// Valid/ready channel carrying one item of a chosen payload type.
// Used for the input and result channels; depends on nothing.
interface imq_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/indexed_min_queue_tournament_tree_core.sv @@
// Indexed min-queue over entry ids 1..LEAF_COUNT, kept as a tournament tree in one
// node memory of 2*P nodes (P = LEAF_COUNT rounded up to a power of two) with one read
// port and one write port.
// After reset the block runs a clearing pass over every node and accepts no item
// meanwhile. An insert/decrease that stores its key or a delete-minimum that removes an
// entry walks from the leaf to the root, one level per cycle through a single compare
// unit, before the next item is accepted; items that change nothing go from the check
// straight to the root and entry reads. The walk rate is set by the one memory read of
// the sibling node per level. A finished result waits in the output register while the
// next item is accepted.
// Depends on imq_pkg, imq_stream_if and imq_node_ram.
module indexed_min_queue_tournament_tree_core
  import imq_pkg::*;
#(
  parameter int LEAF_COUNT = 1024,
  parameter int KEY_BITS   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imq_stream_if.sink   in_i,
  imq_stream_if.source out_o
);

  localparam int LVL   = $clog2(LEAF_COUNT);
  localparam int IDX_W = LVL;
  localparam int AW    = LVL + 1;
  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  localparam logic [AW-1:0] ROOT = AW'(1);

  typedef struct packed {
    logic             present;
    logic [IDX_W-1:0] idx;
    logic [KW-1:0]    key;
  } node_t;

  localparam int NW = $bits(node_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_CLIMB,
    S_RD_ROOT,
    S_RD_ENT,
    S_DONE
  } state_e;

  // A present node beats an absent one; the left node wins ties.
  function automatic node_t pick(node_t a, node_t b);
    node_t r;
    r = a;
    if (a.present != b.present) begin
      r = a.present ? a : b;
    end else if (a.present && (b.key < a.key)) begin
      r = b;
    end
    return r;
  endfunction

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  logic            out_valid_q;
  imq_out_t        out_q;
  logic            changed_q;
  logic            bad_q;

  logic [1:0]      mode_q;
  logic            in_range_q;
  logic [AW-1:0]   leaf_q;
  logic [KW-1:0]   nkey_q;
  node_t           cur_q;
  logic [AW-1:0]   pos_q;
  node_t           root_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  node_t           ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [NW-1:0]   ram_rdata;
  node_t           rd;

  logic [31:0]     in_eid_ext;
  logic [31:0]     in_eid_m1;
  logic            in_range;
  logic [AW-1:0]   in_leaf;
  logic            ins_ok;
  logic            del_ok;
  node_t           new_node;
  node_t           del_node;
  logic [AW-1:0]   del_pos;
  logic [AW-1:0]   parent;
  node_t           win;
  logic [31:0]     root_id;
  logic            ent_present;

  imq_node_ram #(
    .ADDR_W (AW),
    .DATA_W (NW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = node_t'(ram_rdata);

  assign in_eid_ext = 32'(in_i.data.entry_id);
  assign in_eid_m1  = in_eid_ext - 32'd1;
  assign in_range   = (in_eid_ext >= 32'd1) && (in_eid_ext <= 32'(LEAF_COUNT));
  assign in_leaf    = {1'b1, in_eid_m1[IDX_W-1:0]};

  assign new_node = '{present: 1'b1, idx: leaf_q[IDX_W-1:0], key: nkey_q};
  assign del_node = '{present: 1'b0, idx: rd.idx, key: rd.key};
  assign del_pos  = {1'b1, rd.idx};

  assign ins_ok = (mode_q == MODE_UPDATE) && in_range_q &&
                  !(rd.present && (rd.key <= nkey_q));
  assign del_ok = (mode_q == MODE_POP_MIN) && rd.present;

  // The node being carried up sits on the left when its position is even.
  assign parent = pos_q >> 1;
  assign win    = pos_q[0] ? pick(rd, cur_q) : pick(cur_q, rd);

  assign root_id     = 32'(root_q.idx) + 32'd1;
  assign ent_present = in_range_q && rd.present;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = cur_q;
    ram_raddr = leaf_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_raddr = (in_i.data.mode == MODE_POP_MIN) ? ROOT : in_leaf;
      end
      S_CHECK: begin
        if (ins_ok) begin
          ram_we    = 1'b1;
          ram_waddr = leaf_q;
          ram_wdata = new_node;
          ram_raddr = leaf_q ^ AW'(1);
        end else if (del_ok) begin
          ram_we    = 1'b1;
          ram_waddr = del_pos;
          ram_wdata = del_node;
          ram_raddr = del_pos ^ AW'(1);
        end
      end
      S_CLIMB: begin
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = win;
        ram_raddr = parent ^ AW'(1);
      end
      S_RD_ROOT: begin
        ram_raddr = ROOT;
      end
      S_RD_ENT, S_DONE: begin
        ram_raddr = leaf_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      changed_q   <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == {AW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            changed_q <= 1'b0;
            bad_q     <= 1'b0;
            state_q   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ins_ok) begin
            changed_q <= 1'b1;
            state_q   <= S_CLIMB;
          end else if (del_ok) begin
            state_q <= S_CLIMB;
          end else begin
            bad_q   <= (mode_q == MODE_POP_MIN);
            state_q <= S_RD_ROOT;
          end
        end
        S_CLIMB: begin
          if (parent == ROOT) begin
            state_q <= S_RD_ROOT;
          end
        end
        S_RD_ROOT: begin
          state_q <= S_RD_ENT;
        end
        S_RD_ENT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q         <= 1'b1;
            out_q.key_changed   <= changed_q;
            out_q.bad_request   <= bad_q;
            out_q.queue_empty   <= !root_q.present;
            out_q.min_entry     <= root_q.present ? root_id[ID_W-1:0] : '0;
            out_q.entry_present <= ent_present;
            out_q.entry_key     <= ent_present ? KEY_W'(rd.key) : '0;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      mode_q     <= in_i.data.mode;
      in_range_q <= in_range;
      leaf_q     <= in_leaf;
      nkey_q     <= in_i.data.new_key[KW-1:0];
    end
    if (state_q == S_CHECK) begin
      if (ins_ok) begin
        cur_q <= new_node;
        pos_q <= leaf_q;
      end else begin
        cur_q <= del_node;
        pos_q <= del_pos;
      end
    end else if (state_q == S_CLIMB) begin
      cur_q <= win;
      pos_q <= parent;
    end
    if (state_q == S_RD_ENT) begin
      root_q <= rd;
    end
  end

endmodule

@@ sv/imq_node_ram.sv @@
// Node memory of the tournament tree: one write port, one read port.
// Read data is registered. No dependencies.
module imq_node_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 43
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/imq_checker.sv @@
// Port-level checks for the indexed min-queue core, bound to its top level.
// Depends on imq_pkg and the core's channel ports.
module imq_checker
  import imq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input imq_out_t out_item_i
);

  // A result that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  // The core works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while another is in flight");

  // An empty queue reports no minimum, and a refused delete leaves it empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.queue_empty || out_item_i.bad_request) |->
      out_item_i.min_entry == '0 && out_item_i.queue_empty && !out_item_i.key_changed)
    else $error("empty queue reported with a minimum");

  // A stored key leaves the entry present, and an absent entry reads as key zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!out_item_i.key_changed ||
                     (out_item_i.entry_present && !out_item_i.queue_empty)) &&
                    (out_item_i.entry_present || out_item_i.entry_key == '0))
    else $error("entry fields inconsistent");

endmodule

bind indexed_min_queue_tournament_tree_core imq_checker u_imq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.data)
);

@@ tb/indexed_min_queue_tournament_tree_core_tb.sv @@
// Self-checking testbench for indexed_min_queue_tournament_tree_core.
// It predicts every result from its own flat copy of the queue and drives both channels with random
// stalls. Depends on imq_pkg, imq_stream_if and the core.
module indexed_min_queue_tournament_tree_core_tb;
  import imq_pkg::*;

  localparam int          LEAF_COUNT  = 1024;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 24;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;

  logic clk_i;
  logic rst_ni;

  imq_stream_if #(.item_t(imq_in_t))  req_if ();
  imq_stream_if #(.item_t(imq_out_t)) rsp_if ();

  indexed_min_queue_tournament_tree_core #(
    .LEAF_COUNT (LEAF_COUNT),
    .KEY_BITS   (32)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Flat image of the queue: one slot per entry id, the tree itself is not modeled.
  bit               entry_held [0:2047];
  logic [KEY_W-1:0] entry_key_mem [0:2047];
  imq_out_t         pending_results [$];

  bit idle_on;
  int error_count;
  int items_sent;
  int results_checked;
  int pops_done;
  int refusals_seen;
  int cycle_count;
  logic [KEY_W-1:0] frontier_floor;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Id of the present entry with the least key, lower id on ties; 0 when the queue is empty.
  function automatic logic [ID_W-1:0] lowest_entry();
    logic [ID_W-1:0] best;
    best = '0;
    for (int i = 1; i <= LEAF_COUNT; i++) begin
      if (entry_held[i] && (best == 0 || entry_key_mem[i] < entry_key_mem[best])) begin
        best = i[ID_W-1:0];
      end
    end
    return best;
  endfunction

  function automatic imq_out_t predict_queue_op(imq_in_t req);
    imq_out_t         res;
    logic [ID_W-1:0]  top;
    bit               hit;
    res = '0;
    hit = (req.entry_id >= 1) && (req.entry_id <= LEAF_COUNT);
    case (req.mode)
      MODE_UPDATE: begin
        if (hit && !(entry_held[req.entry_id] && entry_key_mem[req.entry_id] <= req.new_key)) begin
          entry_held[req.entry_id]    = 1'b1;
          entry_key_mem[req.entry_id] = req.new_key;
          res.key_changed             = 1'b1;
        end else begin
          refusals_seen++;
        end
      end
      MODE_POP_MIN: begin
        top = lowest_entry();
        if (top == 0) begin
          res.bad_request = 1'b1;
        end else begin
          entry_held[top] = 1'b0;
          pops_done++;
        end
      end
      default: ;
    endcase
    top             = lowest_entry();
    res.queue_empty = (top == 0);
    res.min_entry   = top;
    if (hit && entry_held[req.entry_id]) begin
      res.entry_present = 1'b1;
      res.entry_key     = entry_key_mem[req.entry_id];
    end
    return res;
  endfunction

  // Drives one item from a falling edge and returns at the falling edge after it was taken.
  // Valid stays high on return so back-to-back items need no extra assignment.
  task automatic send_request(input logic [1:0] mode, input logic [ID_W-1:0] id,
                              input logic [KEY_W-1:0] key);
    imq_in_t req;
    req.mode     = mode;
    req.entry_id = id;
    req.new_key  = key;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = req;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(predict_queue_op(req));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_request(MODE_READ, 11'd1, '0);
    send_request(MODE_POP_MIN, 11'd0, '0);
    send_request(MODE_SPARE, 11'd2047, 32'hFFFF_FFFF);
    send_request(MODE_UPDATE, 11'd0, 32'd5);
    send_request(MODE_UPDATE, 11'd1025, 32'd5);
  endtask

  task automatic test_update_rules();
    send_request(MODE_UPDATE, 11'd1024, 32'hFFFF_FFFF);
    send_request(MODE_UPDATE, 11'd1, 32'd0);
    send_request(MODE_UPDATE, 11'd1, 32'd0);
    send_request(MODE_UPDATE, 11'd1, 32'd7);
    send_request(MODE_UPDATE, 11'd5, 32'd100);
    send_request(MODE_UPDATE, 11'd5, 32'd3);
    send_request(MODE_READ, 11'd1024, 32'hFFFF_FFFF);
  endtask

  // Entries 5 and 9 share a key, so the lower id must come out first.
  task automatic test_ties_and_pop();
    send_request(MODE_UPDATE, 11'd9, 32'd3);
    send_request(MODE_POP_MIN, 11'd1, '0);
    send_request(MODE_POP_MIN, 11'd9, '0);
    send_request(MODE_POP_MIN, 11'd1024, '0);
    send_request(MODE_POP_MIN, 11'd2047, '0);
    send_request(MODE_POP_MIN, 11'd1024, '0);
    send_request(MODE_READ, 11'd1024, '0);
  endtask

  // Shortest-path style traffic: keys grow from the last popped key, with reads and some noise.
  task automatic test_random_frontier(input int count, input int id_span,
                                      input logic [KEY_W-1:0] key_span, input int pop_share);
    int              pick;
    logic [ID_W-1:0] top;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < pop_share) begin
        top = lowest_entry();
        if (top != 0) frontier_floor = entry_key_mem[top];
        send_request(MODE_POP_MIN, 11'($urandom_range(0, 2047)), $urandom());
      end else if (pick < 78) begin
        send_request(MODE_UPDATE, 11'($urandom_range(1, id_span)),
                     (key_span == '1) ? $urandom() : frontier_floor + $urandom_range(0, key_span));
      end else if (pick < 93) begin
        send_request(MODE_READ, 11'($urandom_range(1, id_span)), $urandom());
      end else if (pick < 96) begin
        send_request(MODE_SPARE, 11'($urandom_range(0, 2047)), $urandom());
      end else begin
        send_request($urandom_range(0, 1) ? MODE_UPDATE : MODE_READ,
                     $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1025, 2047)),
                     $urandom());
      end
    end
  endtask

  // Output side: ready drops in random bursts while idling is on.
  initial begin
    rsp_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    imq_out_t want;
    imq_out_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.key_changed !== want.key_changed)
          $display("%0t: key_changed exp %0d got %0d", $time, want.key_changed, got.key_changed);
        if (got.bad_request !== want.bad_request)
          $display("%0t: bad_request exp %0d got %0d", $time, want.bad_request, got.bad_request);
        if (got.queue_empty !== want.queue_empty)
          $display("%0t: queue_empty exp %0d got %0d", $time, want.queue_empty, got.queue_empty);
        if (got.min_entry !== want.min_entry)
          $display("%0t: min_entry exp %0d got %0d", $time, want.min_entry, got.min_entry);
        if (got.entry_present !== want.entry_present)
          $display("%0t: entry_present exp %0d got %0d", $time, want.entry_present,
                   got.entry_present);
        if (got.entry_key !== want.entry_key)
          $display("%0t: entry_key exp %h got %h", $time, want.entry_key, got.entry_key);
        if (got !== want) error_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("indexed_min_queue_tournament_tree_core_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.data     = '0;
    idle_on         = 1'b1;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    pops_done       = 0;
    refusals_seen   = 0;
    cycle_count     = 0;
    frontier_floor  = '0;
    for (int i = 0; i < 2048; i++) begin
      entry_held[i]    = 1'b0;
      entry_key_mem[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_update_rules();
    test_ties_and_pop();
    test_random_frontier(300, 8, 32'd15, 22);
    test_random_frontier(450, 64, 32'd1000, 20);
    test_random_frontier(300, LEAF_COUNT, '1, 15);
    idle_on = 1'b0;
    test_random_frontier(120, LEAF_COUNT, 32'd255, 60);
    test_random_frontier(100, 32, 32'd40, 35);
    req_if.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results: %0d pops, %0d updates refused or ignored.",
             items_sent, results_checked, pops_done, refusals_seen);
    if (error_count == 0) begin
      $display("indexed_min_queue_tournament_tree_core_tb: clean");
    end else begin
      $display("indexed_min_queue_tournament_tree_core_tb: errors");
    end
    $finish;
  end

endmodule
